/* rtl/core/ppta_pkg.sv */
// Shared constants, types and helpers for per-peer traffic accounting.
`default_nettype none
package ppta_pkg;

    localparam int PEER_SLOTS  = 16;
    localparam int SLOT_W      = $clog2(PEER_SLOTS);
    localparam int IDX_W       = SLOT_W + 1;
    localparam int LOCAL_ADDRS = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_NUM_W   = 48;
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

    localparam logic [15:0] MIN_CAPTURE = 16'd34;
    localparam logic [15:0] ETH_IPV4    = 16'h0800;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;

    // Item command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Division operand selects
    typedef enum logic [1:0] {
        DIV_PDOWN = 2'd0,
        DIV_PUP   = 2'd1,
        DIV_TDOWN = 2'd2,
        DIV_TUP   = 2'd3
    } ppta_div_sel_t;

    typedef struct packed {
        logic          load_item;
        logic          look;
        logic          upd;
        logic          load_peer;
        logic          load_total;
        logic          idx_inc;
        logic          div_start;
        logic          div_store;
        ppta_div_sel_t div_sel;
    } ppta_cmd_t;

    typedef struct packed {
        logic scan_hit;
        logic idx_end;
        logic div_done;
        logic line_total;
    } ppta_sts_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {33'd0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/per_peer_traffic_accounting.sv */
// Top level of per-peer traffic accounting.
`default_nettype none
// A packet word (cmd 0) passes through accept, peer table match against all
// 16 slots in parallel, then counter update; it gives no result. A report word
// (cmd 1) scans the 16 slots, one per cycle between lines, and for each active
// peer and for the final total line runs four divisions through one bit-serial
// divider of 48 steps; a line then waits for out_ready. Result words are held
// on the outputs until taken; the total line carries last. The user must write
// local addresses through cfg_we, cfg_index and cfg_data only while the block
// is idle; the block does not enforce this. No clearing pass after reset.
module per_peer_traffic_accounting (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [15:0] captured_len,
    input  wire logic [15:0] ether_kind,
    input  wire logic [3:0]  header_words,
    input  wire logic [15:0] total_len,
    input  wire logic [31:0] source_addr,
    input  wire logic [31:0] dest_addr,
    input  wire logic [31:0] period_ticks,
    input  wire logic [31:0] elapsed_ticks,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_total,
    output logic [31:0]      peer_addr,
    output logic [31:0]      down_rate,
    output logic [31:0]      up_rate,
    output logic [47:0]      avg_down_rate,
    output logic [47:0]      avg_up_rate,
    output logic [31:0]      period_rx_bytes,
    output logic [31:0]      period_tx_bytes,
    output logic [31:0]      period_rx_packets,
    output logic [31:0]      period_tx_packets,
    output logic             last
);
    import ppta_pkg::*;

    ppta_cmd_t cmd_bus;
    ppta_sts_t sts;

    ppta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item_cmd  (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd_bus   (cmd_bus),
        .sts       (sts)
    );

    ppta_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_bus           (cmd_bus),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .captured_len      (captured_len),
        .ether_kind        (ether_kind),
        .header_words      (header_words),
        .total_len         (total_len),
        .source_addr       (source_addr),
        .dest_addr         (dest_addr),
        .period_ticks      (period_ticks),
        .elapsed_ticks     (elapsed_ticks),
        .is_total          (is_total),
        .peer_addr         (peer_addr),
        .down_rate         (down_rate),
        .up_rate           (up_rate),
        .avg_down_rate     (avg_down_rate),
        .avg_up_rate       (avg_up_rate),
        .period_rx_bytes   (period_rx_bytes),
        .period_tx_bytes   (period_tx_bytes),
        .period_rx_packets (period_rx_packets),
        .period_tx_packets (period_tx_packets)
    );

    // The total line always closes a report
    assign last = is_total;

endmodule
`default_nettype wire

/* rtl/core/ppta_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle; zero divisor gives 0.
`default_nettype none
module ppta_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [ppta_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic [ppta_pkg::DIV_DEN_W-1:0]  den,
    output logic                                 done,
    output logic [ppta_pkg::DIV_NUM_W-1:0]       quo
);
    import ppta_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic                 zero_reg, zero_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, q_reg[DIV_NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Step one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[DIV_DEN_W-1:0];
                q_next   = {q_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIV_DEN_W-1:0];
                q_next   = {q_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands
    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : q_reg;

endmodule
`default_nettype wire

/* rtl/core/ppta_dp.sv */
// Datapath: local addresses, peer table, global counters, report line and divider.
`default_nettype none
module ppta_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ppta_pkg::ppta_cmd_t               cmd_bus,
    output ppta_pkg::ppta_sts_t                    sts,
    input  wire logic                              cfg_we,
    input  wire logic [ppta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppta_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [15:0]                       captured_len,
    input  wire logic [15:0]                       ether_kind,
    input  wire logic [3:0]                        header_words,
    input  wire logic [15:0]                       total_len,
    input  wire logic [31:0]                       source_addr,
    input  wire logic [31:0]                       dest_addr,
    input  wire logic [31:0]                       period_ticks,
    input  wire logic [31:0]                       elapsed_ticks,
    output logic                                   is_total,
    output logic [31:0]                            peer_addr,
    output logic [31:0]                            down_rate,
    output logic [31:0]                            up_rate,
    output logic [47:0]                            avg_down_rate,
    output logic [47:0]                            avg_up_rate,
    output logic [31:0]                            period_rx_bytes,
    output logic [31:0]                            period_tx_bytes,
    output logic [31:0]                            period_rx_packets,
    output logic [31:0]                            period_tx_packets
);
    import ppta_pkg::*;

    // Configuration
    logic [31:0] local_addr_reg [LOCAL_ADDRS];
    logic [2:0]  local_count_reg;

    // Latched item
    logic [15:0] pay_reg;
    logic        ok_reg;
    logic [31:0] src_reg, dst_reg, per_reg, el_reg;

    // Lookup result
    logic              incoming_reg;
    logic [31:0]       key_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              slot_ok_reg;
    logic              new_reg;

    // Peer table
    logic [PEER_SLOTS-1:0] valid_reg;
    logic [31:0] paddr_reg  [PEER_SLOTS];
    logic [31:0] pdn_per_reg[PEER_SLOTS];
    logic [31:0] pup_per_reg[PEER_SLOTS];
    logic [47:0] pdn_tot_reg[PEER_SLOTS];
    logic [47:0] pup_tot_reg[PEER_SLOTS];

    // Global counters
    logic [31:0] rx_pb_reg, tx_pb_reg, rx_pk_reg, tx_pk_reg;
    logic [47:0] rx_tb_reg, tx_tb_reg;

    // Report line
    logic [IDX_W-1:0] idx_reg;
    logic             ln_total_reg;
    logic [31:0]      ln_addr_reg, ln_pdn_reg, ln_pup_reg, ln_rxp_reg, ln_txp_reg;
    logic [47:0]      ln_tdn_reg, ln_tup_reg;
    logic [31:0]      q_dn_reg, q_up_reg;
    logic [47:0]      q_tdn_reg, q_tup_reg;

    logic [5:0]           hbytes;
    logic [2:0]           n_local;
    logic                 dst_local;
    logic [31:0]          key;
    logic [PEER_SLOTS-1:0] hit_vec;
    logic                 hit_any, free_any;
    logic [SLOT_W-1:0]    hit_slot, free_slot;
    logic [SLOT_W-1:0]    idx;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [31:0]          base_dn_per, base_up_per;
    logic [47:0]          base_dn_tot, base_up_tot;

    assign hbytes = {header_words, 2'b00};
    assign idx    = idx_reg[SLOT_W-1:0];

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOCAL_ADDRS; i++)
            begin
                local_addr_reg[i] <= '0;
            end
            local_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ADDR_A: local_addr_reg[0] <= cfg_data;
                REG_ADDR_B: local_addr_reg[1] <= cfg_data;
                REG_ADDR_C: local_addr_reg[2] <= cfg_data;
                REG_ADDR_D: local_addr_reg[3] <= cfg_data;
                REG_COUNT:  local_count_reg   <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    // Local address match and table search
    always_comb
    begin
        n_local   = (local_count_reg > 3'(LOCAL_ADDRS)) ? 3'(LOCAL_ADDRS) : local_count_reg;
        dst_local = 1'b0;
        for (int i = 0; i < LOCAL_ADDRS; i++)
        begin
            if ((3'(i) < n_local) && (local_addr_reg[i] == dst_reg))
            begin
                dst_local = 1'b1;
            end
        end
        key       = dst_local ? src_reg : dst_reg;
        hit_any   = 1'b0;
        free_any  = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = 0; i < PEER_SLOTS; i++)
        begin
            hit_vec[i] = valid_reg[i] && (paddr_reg[i] == key);
        end
        for (int i = PEER_SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_any  = 1'b1;
                hit_slot = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    // Latch item and lookup results
    always_ff @(posedge clk)
    begin
        if (cmd_bus.load_item)
        begin
            pay_reg <= (total_len > {10'd0, hbytes}) ? (total_len - {10'd0, hbytes}) : 16'd0;
            ok_reg  <= (captured_len >= MIN_CAPTURE) && (ether_kind == ETH_IPV4);
            src_reg <= source_addr;
            dst_reg <= dest_addr;
            per_reg <= period_ticks;
            el_reg  <= elapsed_ticks;
        end
        if (cmd_bus.look)
        begin
            incoming_reg <= dst_local;
            key_reg      <= key;
            slot_reg     <= hit_any ? hit_slot : free_slot;
            slot_ok_reg  <= hit_any || free_any;
            new_reg      <= !hit_any;
        end
    end

    // Entry base values: a new peer starts from zero
    assign base_dn_per = new_reg ? '0 : pdn_per_reg[slot_reg];
    assign base_up_per = new_reg ? '0 : pup_per_reg[slot_reg];
    assign base_dn_tot = new_reg ? '0 : pdn_tot_reg[slot_reg];
    assign base_up_tot = new_reg ? '0 : pup_tot_reg[slot_reg];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd_bus.upd && ok_reg && slot_ok_reg)
        begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    // Update peer entries; clear period counts as a line is loaded
    always_ff @(posedge clk)
    begin
        if (cmd_bus.upd && ok_reg && slot_ok_reg)
        begin
            paddr_reg[slot_reg] <= key_reg;
            if (incoming_reg)
            begin
                pdn_per_reg[slot_reg] <= base_dn_per;
                pdn_tot_reg[slot_reg] <= base_dn_tot;
                pup_per_reg[slot_reg] <= sat_add32(base_up_per, pay_reg);
                pup_tot_reg[slot_reg] <= sat_add48(base_up_tot, pay_reg);
            end
            else
            begin
                pdn_per_reg[slot_reg] <= sat_add32(base_dn_per, pay_reg);
                pdn_tot_reg[slot_reg] <= sat_add48(base_dn_tot, pay_reg);
                pup_per_reg[slot_reg] <= base_up_per;
                pup_tot_reg[slot_reg] <= base_up_tot;
            end
        end
        else if (cmd_bus.load_peer)
        begin
            pdn_per_reg[idx] <= '0;
            pup_per_reg[idx] <= '0;
        end
    end

    // Global counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_pb_reg <= '0;
            tx_pb_reg <= '0;
            rx_pk_reg <= '0;
            tx_pk_reg <= '0;
            rx_tb_reg <= '0;
            tx_tb_reg <= '0;
        end
        else if (cmd_bus.upd && ok_reg)
        begin
            if (incoming_reg)
            begin
                rx_pk_reg <= sat_add32(rx_pk_reg, 16'd1);
                rx_pb_reg <= sat_add32(rx_pb_reg, pay_reg);
                rx_tb_reg <= sat_add48(rx_tb_reg, pay_reg);
            end
            else
            begin
                tx_pk_reg <= sat_add32(tx_pk_reg, 16'd1);
                tx_pb_reg <= sat_add32(tx_pb_reg, pay_reg);
                tx_tb_reg <= sat_add48(tx_tb_reg, pay_reg);
            end
        end
        else if (cmd_bus.load_total)
        begin
            rx_pb_reg <= '0;
            tx_pb_reg <= '0;
            rx_pk_reg <= '0;
            tx_pk_reg <= '0;
        end
    end

    // Advance the report scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd_bus.load_item)
        begin
            idx_reg <= '0;
        end
        else if (cmd_bus.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Load a report line
    always_ff @(posedge clk)
    begin
        if (cmd_bus.load_peer)
        begin
            ln_total_reg <= 1'b0;
            ln_addr_reg  <= paddr_reg[idx];
            ln_pdn_reg   <= pdn_per_reg[idx];
            ln_pup_reg   <= pup_per_reg[idx];
            ln_tdn_reg   <= pdn_tot_reg[idx];
            ln_tup_reg   <= pup_tot_reg[idx];
            ln_rxp_reg   <= '0;
            ln_txp_reg   <= '0;
        end
        else if (cmd_bus.load_total)
        begin
            ln_total_reg <= 1'b1;
            ln_addr_reg  <= '0;
            ln_pdn_reg   <= rx_pb_reg;
            ln_pup_reg   <= tx_pb_reg;
            ln_tdn_reg   <= rx_tb_reg;
            ln_tup_reg   <= tx_tb_reg;
            ln_rxp_reg   <= rx_pk_reg;
            ln_txp_reg   <= tx_pk_reg;
        end
        if (cmd_bus.div_store)
        begin
            case (cmd_bus.div_sel)
                DIV_PDOWN: q_dn_reg  <= div_quo[31:0];
                DIV_PUP:   q_up_reg  <= div_quo[31:0];
                DIV_TDOWN: q_tdn_reg <= div_quo;
                DIV_TUP:   q_tup_reg <= div_quo;
                default:   ;
            endcase
        end
    end

    // Select divider operands
    always_comb
    begin
        case (cmd_bus.div_sel)
            DIV_PDOWN: div_num = {16'd0, ln_pdn_reg};
            DIV_PUP:   div_num = {16'd0, ln_pup_reg};
            DIV_TDOWN: div_num = ln_tdn_reg;
            DIV_TUP:   div_num = ln_tup_reg;
            default:   div_num = '0;
        endcase
        div_den = ((cmd_bus.div_sel == DIV_PDOWN) || (cmd_bus.div_sel == DIV_PUP))
                  ? per_reg : el_reg;
    end

    ppta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd_bus.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign sts.scan_hit   = valid_reg[idx]
                            && ((pdn_per_reg[idx] != '0) || (pup_per_reg[idx] != '0));
    assign sts.idx_end    = (idx_reg == IDX_W'(PEER_SLOTS));
    assign sts.div_done   = div_done;
    assign sts.line_total = ln_total_reg;

    assign is_total          = ln_total_reg;
    assign peer_addr         = ln_addr_reg;
    assign down_rate         = q_dn_reg;
    assign up_rate           = q_up_reg;
    assign avg_down_rate     = q_tdn_reg;
    assign avg_up_rate       = q_tup_reg;
    assign period_rx_bytes   = ln_pdn_reg;
    assign period_tx_bytes   = ln_pup_reg;
    assign period_rx_packets = ln_rxp_reg;
    assign period_tx_packets = ln_txp_reg;

endmodule
`default_nettype wire

/* rtl/core/ppta_ctrl.sv */
// Controller state machine: packet lookup and update, report scan and divisions.
`default_nettype none
module ppta_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 item_cmd,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ppta_pkg::ppta_cmd_t       cmd_bus,
    input  wire ppta_pkg::ppta_sts_t  sts
);
    import ppta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_UPD,
        S_SCAN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    state_t        state_reg, state_next;
    ppta_div_sel_t sel_reg, sel_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd_bus    = '0;
        cmd_bus.div_sel = sel_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_bus.load_item = 1'b1;
                    state_next = (item_cmd == CMD_REPORT) ? S_SCAN : S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd_bus.look = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                cmd_bus.upd = 1'b1;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                sel_next = DIV_PDOWN;
                if (sts.idx_end)
                begin
                    cmd_bus.load_total = 1'b1;
                    state_next = S_DIV_GO;
                end
                else if (sts.scan_hit)
                begin
                    cmd_bus.load_peer = 1'b1;
                    state_next = S_DIV_GO;
                end
                else
                begin
                    cmd_bus.idx_inc = 1'b1;
                end
            end
            S_DIV_GO:
            begin
                cmd_bus.div_start = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd_bus.div_store = 1'b1;
                    if (sel_reg == DIV_TUP)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        sel_next   = ppta_div_sel_t'(sel_reg + 2'd1);
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.line_total)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd_bus.idx_inc = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DIV_PDOWN;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule
`default_nettype wire

/* bench/per_peer_traffic_accounting_tb.sv */
// Self-checking bench for per-peer traffic accounting: directed table, random words, predictor.
`timescale 1ns / 100ps
module per_peer_traffic_accounting_tb;
    import ppta_pkg::*;

    localparam int CYCLE_LIMIT  = 10000000;
    localparam int SETTLE_CYC   = 12;
    localparam int HOLD_CYC     = 3000;
    localparam int POOL_N       = 24;
    localparam logic [31:0] M32 = 32'hFFFF_FFFF;
    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic        cmd;
        logic [15:0] captured_len;
        logic [15:0] ether_kind;
        logic [3:0]  header_words;
        logic [15:0] total_len;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [31:0] period_ticks;
        logic [31:0] elapsed_ticks;
    } traffic_word_t;

    typedef struct {
        logic        is_total;
        logic [31:0] peer_addr;
        logic [31:0] down_rate;
        logic [31:0] up_rate;
        logic [47:0] avg_down_rate;
        logic [47:0] avg_up_rate;
        logic [31:0] period_rx_bytes;
        logic [31:0] period_tx_bytes;
        logic [31:0] period_rx_packets;
        logic [31:0] period_tx_packets;
        logic        last;
    } report_line_t;

    typedef enum logic [1:0] { ROW_WORD, ROW_TYPED, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        traffic_word_t word;
        report_line_t  line;
        logic [2:0]    idx;
        logic [31:0]   data;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = 1'b0;
    logic [15:0] captured_len = '0;
    logic [15:0] ether_kind = '0;
    logic [3:0] header_words = '0;
    logic [15:0] total_len = '0;
    logic [31:0] source_addr = '0;
    logic [31:0] dest_addr = '0;
    logic [31:0] period_ticks = '0;
    logic [31:0] elapsed_ticks = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic is_total, last;
    logic [31:0] peer_addr, down_rate, up_rate;
    logic [47:0] avg_down_rate, avg_up_rate;
    logic [31:0] period_rx_bytes, period_tx_bytes, period_rx_packets, period_tx_packets;

    per_peer_traffic_accounting dut (.*);

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic [31:0] host_addr [4];
    logic [2:0]  host_count;
    logic        slot_used [PEER_SLOTS];
    logic [31:0] slot_addr [PEER_SLOTS];
    logic [31:0] slot_down_per [PEER_SLOTS];
    logic [31:0] slot_up_per [PEER_SLOTS];
    logic [47:0] slot_down_tot [PEER_SLOTS];
    logic [47:0] slot_up_tot [PEER_SLOTS];
    logic [31:0] rx_per_bytes, tx_per_bytes, rx_per_pkts, tx_per_pkts;
    logic [47:0] rx_tot_bytes, tx_tot_bytes;

    report_line_t expected_lines [$];
    logic [31:0]  peer_pool [POOL_N];
    table_row_t   stim_table [$];

    int mismatches = 0;
    int lines_seen = 0;
    int words_sent = 0;
    int reports_sent = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? M32 : s[31:0];
    endfunction

    function automatic logic [47:0] add48(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? M48 : s[47:0];
    endfunction

    function automatic logic [47:0] ratio(logic [47:0] n, logic [31:0] d);
        return (d == 0) ? 48'd0 : n / d;
    endfunction

    function automatic bit host_owns(logic [31:0] a);
        int n;
        n = (host_count > LOCAL_ADDRS) ? LOCAL_ADDRS : host_count;
        for (int i = 0; i < n; i++)
            if (host_addr[i] == a) return 1'b1;
        return 1'b0;
    endfunction

    // Append one expected line at the tail of the queue
    task automatic queue_line(report_line_t l);
        expected_lines = {expected_lines, l};
    endtask

    // Append one row at the tail of the stimulus table
    task automatic add_row(table_row_t r);
        stim_table = {stim_table, r};
    endtask

    // Find the peer slot or claim the lowest free one; -1 when the table is full
    function automatic int claim_slot(logic [31:0] a);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < PEER_SLOTS; i++)
        begin
            if (slot_used[i])
            begin
                if (slot_addr[i] == a) return i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (free_slot >= 0)
        begin
            slot_used[free_slot]     = 1'b1;
            slot_addr[free_slot]     = a;
            slot_down_per[free_slot] = '0;
            slot_up_per[free_slot]   = '0;
            slot_down_tot[free_slot] = '0;
            slot_up_tot[free_slot]   = '0;
        end
        return free_slot;
    endfunction

    function automatic report_line_t make_line(logic tot, logic [31:0] a, logic [31:0] per,
                                               logic [31:0] el, logic [31:0] pd, logic [31:0] pu,
                                               logic [47:0] td, logic [47:0] tu,
                                               logic [31:0] rxp, logic [31:0] txp);
        report_line_t l;
        l.is_total          = tot;
        l.peer_addr         = a;
        l.down_rate         = 32'(ratio({16'd0, pd}, per));
        l.up_rate           = 32'(ratio({16'd0, pu}, per));
        l.avg_down_rate     = ratio(td, el);
        l.avg_up_rate       = ratio(tu, el);
        l.period_rx_bytes   = pd;
        l.period_tx_bytes   = pu;
        l.period_rx_packets = rxp;
        l.period_tx_packets = txp;
        l.last              = tot;
        return l;
    endfunction

    // Update counters for one accepted word and queue the lines it produces
    task automatic predict_traffic(traffic_word_t w, bit use_typed, report_line_t typed);
        logic [31:0] pay, hb;
        int s;
        if (w.cmd == CMD_PACKET)
        begin
            hb  = {26'd0, w.header_words, 2'b00};
            pay = ({16'd0, w.total_len} > hb) ? {16'd0, w.total_len} - hb : 32'd0;
            if (w.captured_len < MIN_CAPTURE || w.ether_kind != ETH_IPV4) return;
            if (host_owns(w.dest_addr))
            begin
                rx_per_pkts  = add32(rx_per_pkts, 32'd1);
                rx_per_bytes = add32(rx_per_bytes, pay);
                rx_tot_bytes = add48(rx_tot_bytes, pay);
                s = claim_slot(w.source_addr);
                if (s >= 0)
                begin
                    slot_up_per[s] = add32(slot_up_per[s], pay);
                    slot_up_tot[s] = add48(slot_up_tot[s], pay);
                end
            end
            else
            begin
                tx_per_pkts  = add32(tx_per_pkts, 32'd1);
                tx_per_bytes = add32(tx_per_bytes, pay);
                tx_tot_bytes = add48(tx_tot_bytes, pay);
                s = claim_slot(w.dest_addr);
                if (s >= 0)
                begin
                    slot_down_per[s] = add32(slot_down_per[s], pay);
                    slot_down_tot[s] = add48(slot_down_tot[s], pay);
                end
            end
        end
        else
        begin
            for (int i = 0; i < PEER_SLOTS; i++)
            begin
                if (!slot_used[i] || (slot_down_per[i] == 0 && slot_up_per[i] == 0)) continue;
                queue_line(make_line(1'b0, slot_addr[i], w.period_ticks,
                    w.elapsed_ticks, slot_down_per[i], slot_up_per[i], slot_down_tot[i],
                    slot_up_tot[i], 32'd0, 32'd0));
                slot_down_per[i] = '0;
                slot_up_per[i]   = '0;
            end
            if (use_typed)
                queue_line(typed);
            else
                queue_line(make_line(1'b1, 32'd0, w.period_ticks, w.elapsed_ticks,
                    rx_per_bytes, tx_per_bytes, rx_tot_bytes, tx_tot_bytes,
                    rx_per_pkts, tx_per_pkts));
            rx_per_bytes = '0;
            tx_per_bytes = '0;
            rx_per_pkts  = '0;
            tx_per_pkts  = '0;
        end
    endtask

    task automatic note_mismatch(string field, logic [47:0] got, logic [47:0] want);
        mismatches++;
        $display("[%0t] mismatch on line %0d: %s got %0h want %0h", $time, lines_seen, field,
                 got, want);
    endtask

    // Drain, let the block settle, then write one register
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < REG_COUNT)
            host_addr[idx] = data;
        else if (idx == REG_COUNT)
            host_count = data[2:0];
    endtask

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(traffic_word_t w, bit use_typed, report_line_t typed);
        cfg_we <= 1'b0;
        if (!quiet && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 19) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= w.cmd;
        captured_len  <= w.captured_len;
        ether_kind    <= w.ether_kind;
        header_words  <= w.header_words;
        total_len     <= w.total_len;
        source_addr   <= w.source_addr;
        dest_addr     <= w.dest_addr;
        period_ticks  <= w.period_ticks;
        elapsed_ticks <= w.elapsed_ticks;
        do @(posedge clk); while (!in_ready);
        predict_traffic(w, use_typed, typed);
        words_sent++;
        if (w.cmd == CMD_REPORT) reports_sent++;
    endtask

    function automatic traffic_word_t pkt(logic [15:0] cap, logic [15:0] kind, logic [3:0] hw,
                                          logic [15:0] tl, logic [31:0] src, logic [31:0] dst);
        traffic_word_t w;
        w = '{CMD_PACKET, cap, kind, hw, tl, src, dst, 32'd0, 32'd0};
        return w;
    endfunction

    function automatic traffic_word_t rpt(logic [31:0] per, logic [31:0] el);
        traffic_word_t w;
        w = '{CMD_REPORT, 16'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
              $urandom, $urandom, per, el};
        return w;
    endfunction

    function automatic table_row_t row(traffic_word_t w);
        table_row_t r;
        r.kind = ROW_WORD;
        r.word = w;
        return r;
    endfunction

    function automatic table_row_t cfg_row(logic [2:0] idx, logic [31:0] data);
        table_row_t r;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Report whose only line is an all-zero total
    function automatic table_row_t empty_report(logic [31:0] per, logic [31:0] el);
        table_row_t r;
        r.kind = ROW_TYPED;
        r.word = rpt(per, el);
        r.line = '{1'b1, 32'd0, 32'd0, 32'd0, 48'd0, 48'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
        return r;
    endfunction

    function automatic logic [31:0] rand_ticks();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 32'd0;
        if (r < 20) return $urandom;
        return $urandom_range(1, 2000);
    endfunction

    function automatic traffic_word_t random_word();
        traffic_word_t w;
        int r, n;
        r = $urandom_range(99);
        if (r < 8) return rpt(rand_ticks(), rand_ticks());
        if (r < 18)
            return pkt(16'($urandom), ($urandom_range(1) ? ETH_IPV4 : 16'($urandom)),
                       4'($urandom), 16'($urandom), $urandom, $urandom);
        w = pkt(($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(34, 1514)),
                ETH_IPV4, 4'($urandom), ($urandom_range(3) == 0) ? 16'($urandom)
                : 16'($urandom_range(0, 1500)), $urandom, $urandom);
        n = (host_count > LOCAL_ADDRS) ? LOCAL_ADDRS : host_count;
        if (n > 0 && $urandom_range(1))
        begin
            w.dest_addr   = host_addr[$urandom_range(n - 1)];
            w.source_addr = peer_pool[$urandom_range(POOL_N - 1)];
        end
        else if ($urandom_range(9) != 0)
            w.dest_addr = peer_pool[$urandom_range(POOL_N - 1)];
        return w;
    endfunction

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d lines outstanding", cycles,
                     expected_lines.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end
        else
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        report_line_t w;
        if (rst_n && out_valid && out_ready)
        begin
            lines_seen++;
            if (expected_lines.size() == 0)
            begin
                note_mismatch("result word with nothing expected", 48'd0, 48'd0);
            end
            else
            begin
                w = expected_lines.pop_front();
                if (is_total !== w.is_total) note_mismatch("is_total", is_total, w.is_total);
                if (peer_addr !== w.peer_addr) note_mismatch("peer_addr", peer_addr, w.peer_addr);
                if (down_rate !== w.down_rate) note_mismatch("down_rate", down_rate, w.down_rate);
                if (up_rate !== w.up_rate) note_mismatch("up_rate", up_rate, w.up_rate);
                if (avg_down_rate !== w.avg_down_rate)
                    note_mismatch("avg_down_rate", avg_down_rate, w.avg_down_rate);
                if (avg_up_rate !== w.avg_up_rate)
                    note_mismatch("avg_up_rate", avg_up_rate, w.avg_up_rate);
                if (period_rx_bytes !== w.period_rx_bytes)
                    note_mismatch("period_rx_bytes", period_rx_bytes, w.period_rx_bytes);
                if (period_tx_bytes !== w.period_tx_bytes)
                    note_mismatch("period_tx_bytes", period_tx_bytes, w.period_tx_bytes);
                if (period_rx_packets !== w.period_rx_packets)
                    note_mismatch("period_rx_packets", period_rx_packets, w.period_rx_packets);
                if (period_tx_packets !== w.period_tx_packets)
                    note_mismatch("period_tx_packets", period_tx_packets, w.period_tx_packets);
                if (last !== w.last) note_mismatch("last", last, w.last);
            end
        end
    end

    // Stimulus
    initial
    begin
        report_line_t none;
        int wait_cyc;
        none = '{1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0};
        for (int i = 0; i < 4; i++) host_addr[i] = '0;
        host_count = '0;
        for (int i = 0; i < PEER_SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_addr[i] = '0;
            slot_down_per[i] = '0;
            slot_up_per[i] = '0;
            slot_down_tot[i] = '0;
            slot_up_tot[i] = '0;
        end
        rx_per_bytes = '0; tx_per_bytes = '0; rx_per_pkts = '0; tx_per_pkts = '0;
        rx_tot_bytes = '0; tx_tot_bytes = '0;
        for (int i = 0; i < POOL_N; i++) peer_pool[i] = $urandom;
        peer_pool[0] = 32'd0;
        peer_pool[1] = M32;

        // Directed table: boundaries of every field and each special case
        add_row(empty_report(32'd0, 32'd0));
        add_row(row(pkt(16'd33, ETH_IPV4, 4'd5, 16'd100, 32'h0A000001, 32'h0A000002)));
        add_row(row(pkt(16'd34, 16'h86DD, 4'd5, 16'd100, 32'h0A000001, 32'h0A000002)));
        add_row(row(pkt(16'd34, ETH_IPV4, 4'd5, 16'd100, 32'h0A000001, 32'h0A000002)));
        add_row(row(pkt(16'hFFFF, ETH_IPV4, 4'd15, 16'd10, 32'h0, 32'h0A000003)));
        add_row(row(pkt(16'd60, ETH_IPV4, 4'd0, 16'hFFFF, 32'h0, M32)));
        add_row(row(rpt(32'd7, 32'd3)));
        add_row(empty_report(32'd0, 32'd0));
        add_row(cfg_row(REG_ADDR_A, 32'hC0A8_0001));
        add_row(cfg_row(REG_ADDR_B, 32'd0));
        add_row(cfg_row(REG_ADDR_C, M32));
        add_row(cfg_row(REG_ADDR_D, 32'h5A5A_A5A5));
        add_row(cfg_row(REG_COUNT, 32'd4));
        add_row(cfg_row(3'd5, M32));
        add_row(row(pkt(16'd64, ETH_IPV4, 4'd5, 16'd1500, 32'h0A000002, 32'hC0A8_0001)));
        add_row(row(pkt(16'd64, ETH_IPV4, 4'd5, 16'd40, 32'h0A000002, 32'd0)));
        add_row(row(pkt(16'd64, ETH_IPV4, 4'd6, 16'd900, M32, M32)));
        add_row(row(pkt(16'd64, ETH_IPV4, 4'd5, 16'd20, 32'h0A000001, 32'h5A5A_A5A5)));
        add_row(row(rpt(32'd0, M32)));
        add_row(cfg_row(REG_COUNT, 32'd7));
        add_row(cfg_row(3'd7, 32'h1234_5678));
        add_row(row(pkt(16'd64, ETH_IPV4, 4'd5, 16'd300, 32'h0A000002, 32'h5A5A_A5A5)));
        add_row(row(rpt(M32, 32'd1)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            case (stim_table[i].kind)
                ROW_CFG:   write_reg(stim_table[i].idx, stim_table[i].data);
                ROW_TYPED: send_word(stim_table[i].word, 1'b1, stim_table[i].line);
                default:   send_word(stim_table[i].word, 1'b0, none);
            endcase
        end

        // Random phases, each under its own address setting
        for (int ph = 0; ph < 5; ph++)
        begin
            for (int r = 0; r < 4; r++)
                write_reg(r[2:0], ($urandom_range(3) == 0) ? peer_pool[$urandom_range(3)]
                                                            : 32'($urandom));
            write_reg(3'($urandom_range(5, 7)), $urandom);
            case (ph)
                0: write_reg(REG_COUNT, 32'd4);
                1: write_reg(REG_COUNT, 32'd0);
                2: write_reg(REG_COUNT, 32'd7);
                3: write_reg(REG_COUNT, 32'd1);
                default: write_reg(REG_COUNT, $urandom);
            endcase
            quiet = (ph == 1);
            for (int k = 0; k < 49; k++)
            begin
                // Hold off the result side behind a report so the input stalls
                if (ph == 3 && k == 10)
                begin
                    hold_req = 1'b1;
                    send_word(rpt(rand_ticks(), rand_ticks()), 1'b0, none);
                end
                else
                    send_word(random_word(), 1'b0, none);
            end
        end
        send_word(rpt(rand_ticks(), rand_ticks()), 1'b0, none);
        quiet = 1'b0;
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;

        // Drain and let the block settle
        while (expected_lines.size() != 0) @(posedge clk);
        wait_cyc = 0;
        while (wait_cyc < 400)
        begin
            @(posedge clk);
            wait_cyc++;
        end

        $display("covered %0d words (%0d reports), %0d result lines across several address setups",
                 words_sent, reports_sent, lines_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ppta_pkg.sv
rtl/core/ppta_div.sv
rtl/core/ppta_dp.sv
rtl/core/ppta_ctrl.sv
rtl/core/per_peer_traffic_accounting.sv
bench/per_peer_traffic_accounting_tb.sv
